[rtl/gspg_pkg.sv]
// Shared constants, sine table and helper functions for the galvo shape point generator.
package gspg_pkg;

    localparam int GSPG_POINTS_DEFAULT = 256;
    localparam int SINE_ROM_SIZE       = 255;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [1:0] SHP_SQUARE = 2'd0;
    localparam logic [1:0] SHP_RECT   = 2'd1;
    localparam logic [1:0] SHP_CIRCLE = 2'd2;

    localparam logic [0:0] REG_AMP_PCT   = 1'b0;
    localparam logic [6:0] AMP_PCT_RESET = 7'd100;
    localparam logic [15:0] DAC_CENTER   = 16'h8000;

    localparam logic [15:0] SINE_ROM [SINE_ROM_SIZE] = '{
        16'd32967, 16'd33775, 16'd34581, 16'd35387, 16'd36190,
        16'd36992, 16'd37791, 16'd38588, 16'd39380, 16'd40169,
        16'd40953, 16'd41732, 16'd42506, 16'd43274, 16'd44035,
        16'd44790, 16'd45537, 16'd46277, 16'd47008, 16'd47731,
        16'd48444, 16'd49148, 16'd49842, 16'd50526, 16'd51199,
        16'd51861, 16'd52511, 16'd53149, 16'd53775, 16'd54388,
        16'd54988, 16'd55575, 16'd56147, 16'd56706, 16'd57250,
        16'd57779, 16'd58292, 16'd58791, 16'd59273, 16'd59740,
        16'd60190, 16'd60623, 16'd61040, 16'd61439, 16'd61821,
        16'd62185, 16'd62532, 16'd62860, 16'd63170, 16'd63462,
        16'd63735, 16'd63989, 16'd64224, 16'd64440, 16'd64637,
        16'd64815, 16'd64973, 16'd65112, 16'd65230, 16'd65330,
        16'd65409, 16'd65469, 16'd65509, 16'd65528, 16'd65528,
        16'd65509, 16'd65469, 16'd65409, 16'd65330, 16'd65230,
        16'd65112, 16'd64973, 16'd64815, 16'd64637, 16'd64440,
        16'd64224, 16'd63989, 16'd63735, 16'd63462, 16'd63170,
        16'd62860, 16'd62532, 16'd62185, 16'd61821, 16'd61439,
        16'd61040, 16'd60623, 16'd60190, 16'd59740, 16'd59273,
        16'd58791, 16'd58292, 16'd57779, 16'd57250, 16'd56706,
        16'd56147, 16'd55575, 16'd54988, 16'd54388, 16'd53775,
        16'd53149, 16'd52511, 16'd51861, 16'd51199, 16'd50526,
        16'd49842, 16'd49148, 16'd48444, 16'd47731, 16'd47008,
        16'd46277, 16'd45537, 16'd44790, 16'd44035, 16'd43274,
        16'd42506, 16'd41732, 16'd40953, 16'd40169, 16'd39380,
        16'd38588, 16'd37791, 16'd36992, 16'd36190, 16'd35387,
        16'd34581, 16'd33775, 16'd32967, 16'd32160, 16'd31353,
        16'd30547, 16'd29742, 16'd28939, 16'd28139, 16'd27341,
        16'd26547, 16'd25756, 16'd24969, 16'd24188, 16'd23411,
        16'd22640, 16'd21876, 16'd21118, 16'd20367, 16'd19623,
        16'd18888, 16'd18161, 16'd17443, 16'd16734, 16'd16034,
        16'd15345, 16'd14667, 16'd14000, 16'd13344, 16'd12699,
        16'd12067, 16'd11448, 16'd10841, 16'd10248, 16'd9668,
        16'd9103,  16'd8552,  16'd8015,  16'd7494,  16'd6988,
        16'd6497,  16'd6022,  16'd5564,  16'd5122,  16'd4697,
        16'd4289,  16'd3899,  16'd3526,  16'd3170,  16'd2833,
        16'd2514,  16'd2213,  16'd1930,  16'd1667,  16'd1422,
        16'd1196,  16'd990,   16'd802,   16'd635,   16'd486,
        16'd358,   16'd248,   16'd159,   16'd90,    16'd40,
        16'd10,    16'd0,     16'd10,    16'd40,    16'd90,
        16'd159,   16'd248,   16'd358,   16'd486,   16'd635,
        16'd802,   16'd990,   16'd1196,  16'd1422,  16'd1667,
        16'd1930,  16'd2213,  16'd2514,  16'd2833,  16'd3170,
        16'd3526,  16'd3899,  16'd4289,  16'd4697,  16'd5122,
        16'd5564,  16'd6022,  16'd6497,  16'd6988,  16'd7494,
        16'd8015,  16'd8552,  16'd9103,  16'd9668,  16'd10248,
        16'd10841, 16'd11448, 16'd12067, 16'd12699, 16'd13344,
        16'd14000, 16'd14667, 16'd15345, 16'd16034, 16'd16734,
        16'd17443, 16'd18161, 16'd18888, 16'd19623, 16'd20367,
        16'd21118, 16'd21876, 16'd22640, 16'd23411, 16'd24188,
        16'd24969, 16'd25756, 16'd26547, 16'd27341, 16'd28139,
        16'd28939, 16'd29742, 16'd30547, 16'd31353, 16'd32160
    };

    function automatic int seg_len(input int points);
        return (points / 4 < 1) ? 1 : points / 4;
    endfunction

    function automatic int seg_w(input int points);
        return (seg_len(points) > 1) ? $clog2(seg_len(points)) : 1;
    endfunction

    function automatic int item_w(input int points);
        return 2 + 8 + 8 + seg_w(points) + 2;
    endfunction

    // amp = floor(32767 * pct / 100) = 327 * pct + floor(67 * pct / 100)
    function automatic logic [14:0] amp_of_pct(input logic [6:0] pct);
        logic [6:0]  p;
        logic [14:0] base;
        logic [12:0] y;
        logic [26:0] yq;
        p    = (pct > 7'd100) ? 7'd100 : pct;
        base = 15'(p) * 15'd327;
        y    = 13'(p) * 13'd67;
        yq   = 27'(y) * 27'd10486;
        return base + 15'(yq[26:20]);
    endfunction

endpackage

[rtl/gspg_front.sv]
// Key edge detection, shape selection and point sequencing.
module gspg_front import gspg_pkg::*; #(
    parameter int POINTS = GSPG_POINTS_DEFAULT,
    localparam int ITEM_W = item_w(POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_keys,
    input  logic              i_full,
    output logic              o_push,
    output logic [ITEM_W-1:0] o_item
);

    localparam int IDX_W  = $clog2(POINTS);
    localparam int SEG    = seg_len(POINTS);
    localparam int T_W    = seg_w(POINTS);
    localparam int K_STEP = SINE_ROM_SIZE / POINTS;
    localparam int K_REM  = SINE_ROM_SIZE % POINTS;

    logic [2:0]       r_keys, n_keys;
    logic [1:0]       r_shape, n_shape;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [7:0]       r_k, n_k;
    logic [T_W-1:0]   r_t, n_t;
    logic [1:0]       r_side, n_side;

    logic             accept;
    logic             restart;
    logic [2:0]       fell;
    logic [1:0]       pick;
    logic [IDX_W-1:0] c_idx, c_rem;
    logic [7:0]       c_k;
    logic [T_W-1:0]   c_t;
    logic [1:0]       c_side;
    logic [IDX_W:0]   rem_sum;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        fell = r_keys & ~i_keys;
        pick = r_shape;
        if (fell[0]) begin
            pick = SHP_SQUARE;
        end
        if (fell[1]) begin
            pick = SHP_RECT;
        end
        if (fell[2]) begin
            pick = SHP_CIRCLE;
        end
        restart = (pick != r_shape);
        c_idx   = restart ? '0 : r_idx;
        c_rem   = restart ? '0 : r_rem;
        c_k     = restart ? '0 : r_k;
        c_t     = restart ? '0 : r_t;
        c_side  = restart ? '0 : r_side;
        rem_sum = {1'b0, c_rem} + (IDX_W+1)'(K_REM);
    end

    assign o_item = {pick, 8'(c_idx), c_k, c_t, c_side};

    always_comb begin
        n_keys  = r_keys;
        n_shape = r_shape;
        n_idx   = r_idx;
        n_rem   = r_rem;
        n_k     = r_k;
        n_t     = r_t;
        n_side  = r_side;
        if (accept) begin
            n_keys  = i_keys;
            n_shape = pick;
            if (c_idx == IDX_W'(POINTS - 1)) begin
                n_idx  = '0;
                n_rem  = '0;
                n_k    = '0;
                n_t    = '0;
                n_side = '0;
            end else begin
                n_idx = c_idx + 1'b1;
                if (rem_sum >= (IDX_W+1)'(POINTS)) begin
                    n_rem = IDX_W'(rem_sum - (IDX_W+1)'(POINTS));
                    n_k   = c_k + 8'(K_STEP + 1);
                end else begin
                    n_rem = IDX_W'(rem_sum);
                    n_k   = c_k + 8'(K_STEP);
                end
                if (c_t == T_W'(SEG - 1)) begin
                    n_t    = '0;
                    n_side = (c_side == 2'd3) ? 2'd3 : c_side + 2'd1;
                end else begin
                    n_t    = c_t + 1'b1;
                    n_side = c_side;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys  <= 3'b111;
            r_shape <= SHP_CIRCLE;
            r_idx   <= '0;
            r_rem   <= '0;
            r_k     <= '0;
            r_t     <= '0;
            r_side  <= '0;
        end else begin
            r_keys  <= n_keys;
            r_shape <= n_shape;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
            r_k     <= n_k;
            r_t     <= n_t;
            r_side  <= n_side;
        end
    end

endmodule

[rtl/gspg_queue.sv]
// Short first-in first-out queue between front and back.
module gspg_queue import gspg_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W:0]   r_wr, n_wr;
    logic [PTR_W:0]   r_rd, n_rd;
    logic [PTR_W:0]   count;

    assign count   = r_wr - r_rd;
    assign o_full  = (count == (PTR_W+1)'(DEPTH));
    assign o_empty = (count == '0);
    assign o_data  = r_mem[r_rd[PTR_W-1:0]];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr[PTR_W-1:0] == PTR_W'(DEPTH - 1)) ?
                   {~r_wr[PTR_W], {PTR_W{1'b0}}} : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd[PTR_W-1:0] == PTR_W'(DEPTH - 1)) ?
                   {~r_rd[PTR_W], {PTR_W{1'b0}}} : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[PTR_W-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

endmodule

[rtl/gspg_back.sv]
// Point geometry pipeline: sine lookup, scaling and DAC code output register.
module gspg_back import gspg_pkg::*; #(
    parameter int POINTS = GSPG_POINTS_DEFAULT,
    localparam int ITEM_W = item_w(POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_amp_pct,
    input  logic              i_empty,
    input  logic [ITEM_W-1:0] i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_x,
    output logic [15:0]       o_y,
    output logic [1:0]        o_shape,
    output logic [7:0]        o_pnum
);

    localparam int SEG   = seg_len(POINTS);
    localparam int T_W   = seg_w(POINTS);
    localparam int ST_W  = 16 + T_W;
    localparam int DIV_S = 16 + $clog2(SEG);
    localparam logic [17:0] DIV_M =
        18'(((longint'(1) << DIV_S) + longint'(SEG) - 1) / longint'(SEG));

    logic [14:0] r_amp;
    logic [15:0] r_step_full, r_step_half;
    logic [33:0] step_full_p, step_half_p;

    logic        en;
    logic [1:0]  i_shape, i_side;
    logic [7:0]  i_pnum, i_k, kx;
    logic [8:0]  kx9;
    logic [T_W-1:0] i_t;
    logic [15:0] step_sel;

    logic             r1_v;
    logic [1:0]       r1_shape, r1_side;
    logic [7:0]       r1_pnum;
    logic [15:0]      r1_rom_x, r1_rom_y;
    logic [ST_W-1:0]  r1_st;

    logic signed [17:0] hw, hh, st, dx, dy;
    logic [15:0] mag_x, mag_y;

    logic        r2_v;
    logic [1:0]  r2_shape;
    logic [7:0]  r2_pnum;
    logic [15:0] r2_sq_x, r2_sq_y;
    logic [30:0] r2_prod_x, r2_prod_y;
    logic        r2_neg_x, r2_neg_y;

    logic [15:0] q_x, q_y;
    logic [15:0] circ_x, circ_y;

    logic        r3_v;
    logic [1:0]  r3_shape;
    logic [7:0]  r3_pnum;
    logic [15:0] r3_x, r3_y;

    // step = floor(2 * half_size / SEG) by reciprocal multiply
    assign step_full_p = 34'({r_amp, 1'b0}) * 34'(DIV_M);
    assign step_half_p = 34'({1'b0, r_amp[14:1], 1'b0}) * 34'(DIV_M);

    always_ff @(posedge i_clk) begin
        r_amp       <= amp_of_pct(i_amp_pct);
        r_step_full <= 16'(step_full_p >> DIV_S);
        r_step_half <= 16'(step_half_p >> DIV_S);
    end

    assign en    = !r3_v || i_ready;
    assign o_pop = en && !i_empty;

    assign i_shape = i_item[ITEM_W-1 -: 2];
    assign i_pnum  = i_item[ITEM_W-3 -: 8];
    assign i_k     = i_item[ITEM_W-11 -: 8];
    assign i_t     = i_item[T_W+1:2];
    assign i_side  = i_item[1:0];

    always_comb begin
        kx9      = {1'b0, i_k} + 9'd64;
        kx       = (kx9 >= 9'(SINE_ROM_SIZE)) ? 8'(kx9 - 9'(SINE_ROM_SIZE)) : kx9[7:0];
        step_sel = (i_shape == SHP_RECT && !i_side[0]) ? r_step_half : r_step_full;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_shape <= i_shape;
            r1_side  <= i_side;
            r1_pnum  <= i_pnum;
            r1_rom_x <= SINE_ROM[kx];
            r1_rom_y <= SINE_ROM[i_k];
            r1_st    <= ST_W'(step_sel) * ST_W'(i_t);
        end
    end

    always_comb begin
        hw = 18'(r_amp);
        hh = (r1_shape == SHP_RECT) ? 18'(r_amp[14:1]) : 18'(r_amp);
        st = 18'(r1_st);
        case (r1_side)
            2'd0: begin
                dx = hw;
                dy = hh - st;
            end
            2'd1: begin
                dx = hw - st;
                dy = -hh;
            end
            2'd2: begin
                dx = -hw;
                dy = -hh + st;
            end
            default: begin
                dx = -hw + st;
                dy = hh;
            end
        endcase
        mag_x = r1_rom_x[15] ? {1'b0, r1_rom_x[14:0]} : DAC_CENTER - r1_rom_x;
        mag_y = r1_rom_y[15] ? {1'b0, r1_rom_y[14:0]} : DAC_CENTER - r1_rom_y;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_shape  <= r1_shape;
            r2_pnum   <= r1_pnum;
            r2_sq_x   <= DAC_CENTER + dx[15:0];
            r2_sq_y   <= DAC_CENTER + dy[15:0];
            r2_prod_x <= 31'(r_amp) * 31'(mag_x);
            r2_prod_y <= 31'(r_amp) * 31'(mag_y);
            r2_neg_x  <= !r1_rom_x[15];
            r2_neg_y  <= !r1_rom_y[15];
        end
    end

    // floor(p / 32767) for p up to 32767 * 32768
    always_comb begin
        q_x    = 16'((r2_prod_x + (r2_prod_x >> 15) + 31'd1) >> 15);
        q_y    = 16'((r2_prod_y + (r2_prod_y >> 15) + 31'd1) >> 15);
        circ_x = DAC_CENTER + (r2_neg_x ? -q_x : q_x);
        circ_y = DAC_CENTER + (r2_neg_y ? -q_y : q_y);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_shape <= r2_shape;
            r3_pnum  <= r2_pnum;
            if (r2_shape == SHP_SQUARE || r2_shape == SHP_RECT) begin
                r3_x <= r2_sq_x;
                r3_y <= r2_sq_y;
            end else begin
                r3_x <= circ_x;
                r3_y <= circ_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= o_pop;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    assign o_valid = r3_v;
    assign o_x     = r3_x;
    assign o_y     = r3_y;
    assign o_shape = r3_shape;
    assign o_pnum  = r3_pnum;

endmodule

[rtl/galvo_shape_point_generator.sv]
// Top level of the galvo shape point generator.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | key levels, one scan tick
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | x, y, shape, point number
//  apb       | in  | psel, penable, pwrite, pready  | amplitude_percent at byte address 0
//
// One point per clock sustained while m_axis_tready stays high; an accepted tick passes
// through the queue, lookup/step multiply, scale multiply, divide-by-32767 and output
// register. An amplitude write reaches the amplitude register, then the scale registers.
// Reset (synchronous, active low): circle shape, point 0, all keys released, 100 percent.
// A four-entry queue absorbs output stalls; s_axis_tready drops only when it is full.
module galvo_shape_point_generator import gspg_pkg::*; #(
    parameter int POINTS_PER_SHAPE = GSPG_POINTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // key_square_level, key_rect_level, key_circle_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // x_code[15:0], y_code[31:16], shape_code[33:32],
                                       // point_number[41:34]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ITEM_W = item_w(POINTS_PER_SHAPE);

    logic [6:0]        r_amp_pct;
    logic              cfg_wr;
    logic              q_push, q_pop, q_full, q_empty;
    logic [ITEM_W-1:0] q_in, q_out;
    logic [15:0]       x_code, y_code;
    logic [1:0]        shape_code;
    logic [7:0]        point_number;
    logic [1:0]        r_prev_shape;
    logic              r_seen;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_AMP_PCT);
    assign prdata = (paddr[2] == REG_AMP_PCT) ? {25'd0, r_amp_pct} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_pct <= AMP_PCT_RESET;
        end else if (cfg_wr) begin
            r_amp_pct <= pwdata[6:0];
        end
    end

    gspg_front #(.POINTS(POINTS_PER_SHAPE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_keys  (s_axis_tdata[2:0]),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_item  (q_in)
    );

    gspg_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gspg_back #(.POINTS(POINTS_PER_SHAPE)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_amp_pct (r_amp_pct),
        .i_empty   (q_empty),
        .i_item    (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_x       (x_code),
        .o_y       (y_code),
        .o_shape   (shape_code),
        .o_pnum    (point_number)
    );

    assign m_axis_tdata = {6'd0, point_number, shape_code, y_code, x_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_prev_shape <= SHP_CIRCLE;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_seen       <= 1'b1;
            r_prev_shape <= shape_code;
        end
    end

    a_full_means_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("queue full while output register is empty");

    a_shape_change_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_seen && shape_code != r_prev_shape) |-> point_number == 8'd0)
        else $error("shape change without point restart");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[2] == REG_AMP_PCT)
        |=> r_amp_pct == $past(pwdata[6:0]))
        else $error("amplitude register did not take write");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the galvo shape point generator: key ticks in, DAC points checked.
module testbench import gspg_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS     = GSPG_POINTS_DEFAULT;
    localparam int KEY_SQUARE = 0;
    localparam int KEY_RECT   = 1;
    localparam int KEY_CIRCLE = 2;
    localparam int QUIET_MAX  = 2000;
    localparam int PHASE_LEN  = 220;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  shape;
        logic [7:0]  pt;
    } t_point;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // key_square_level, key_rect_level, key_circle_level
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // x_code, y_code, shape_code, point_number
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    galvo_shape_point_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    logic [2:0] tick_levels[$];
    t_point     expected_points[$];
    int         err_cnt   = 0;
    int         quiet_cnt = 0;
    int         send_hold = 0;
    int         recv_hold = 0;
    bit         idle_on   = 1'b1;

    logic [6:0] amp_pct   = AMP_PCT_RESET;
    logic [1:0] cur_shape = SHP_CIRCLE;
    int         pt_idx    = 0;
    logic [2:0] last_keys = 3'b111;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_point point_at(logic [1:0] shp, int idx);
        int     amp, seg, hw, hh, sx, sy, side, t, dx, dy, kk;
        t_point p;
        amp = 32767 * ((amp_pct > 7'd100) ? 100 : int'(amp_pct)) / 100;
        if (shp == SHP_SQUARE || shp == SHP_RECT) begin
            seg  = (POINTS / 4 < 1) ? 1 : POINTS / 4;
            hw   = amp;
            hh   = (shp == SHP_SQUARE) ? amp : amp / 2;
            sx   = 2 * hw / seg;
            sy   = 2 * hh / seg;
            side = idx / seg;
            t    = idx % seg;
            case (side)
                0: begin
                    dx = hw;
                    dy = hh - sy * t;
                end
                1: begin
                    dx = hw - sx * t;
                    dy = -hh;
                end
                2: begin
                    dx = -hw;
                    dy = -hh + sy * t;
                end
                default: begin
                    dx = -hw + sx * t;
                    dy = hh;
                end
            endcase
        end else begin
            kk = (idx * SINE_ROM_SIZE / POINTS) % SINE_ROM_SIZE;
            dx = int'((longint'(amp) *
                       (longint'(SINE_ROM[(kk + 64) % SINE_ROM_SIZE]) - 32768)) / 32767);
            dy = int'((longint'(amp) * (longint'(SINE_ROM[kk]) - 32768)) / 32767);
        end
        p.x     = 16'(32768 + dx);
        p.y     = 16'(32768 + dy);
        p.shape = shp;
        p.pt    = 8'(idx);
        return p;
    endfunction

    task automatic take_tick(input logic [2:0] keys);
        logic [2:0] fell;
        logic [1:0] pick;
        fell = last_keys & ~keys;
        pick = cur_shape;
        if (fell[KEY_SQUARE])
            pick = SHP_SQUARE;
        if (fell[KEY_RECT])
            pick = SHP_RECT;
        if (fell[KEY_CIRCLE])
            pick = SHP_CIRCLE;
        last_keys = keys;
        if (pick != cur_shape) begin
            cur_shape = pick;
            pt_idx    = 0;
        end
        expected_points.push_back(point_at(cur_shape, pt_idx));
        pt_idx = (pt_idx + 1) % POINTS;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                take_tick(s_axis_tdata[2:0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_levels.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, tick_levels.pop_front()};
                    send_hold = pick_idle();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_points.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected point transaction: %h", m_axis_tdata);
                end else begin
                    want = expected_points.pop_front();
                    if (m_axis_tdata[15:0] !== want.x || m_axis_tdata[31:16] !== want.y ||
                        m_axis_tdata[33:32] !== want.shape ||
                        m_axis_tdata[41:34] !== want.pt) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("point mismatch: exp x=%h y=%h shape=%0d pt=%0d,",
                                     want.x, want.y, want.shape, want.pt,
                                     " got x=%h y=%h shape=%0d pt=%0d",
                                     m_axis_tdata[15:0], m_axis_tdata[31:16],
                                     m_axis_tdata[33:32], m_axis_tdata[41:34]);
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_hold = pick_idle();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= QUIET_MAX) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    task automatic write_amp(input logic [6:0] pct);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_AMP_PCT) << 2;
        pwdata  <= {25'b0, pct};
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        amp_pct = pct;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic drain();
        do
            @(negedge i_clk);
        while (tick_levels.size() > 0 || s_axis_tvalid || expected_points.size() > 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic fill_random(input int n);
        int         left, run, hold;
        logic [2:0] mask;
        left = n;
        while (left > 0) begin
            run = ($urandom_range(0, 9) < 3) ? $urandom_range(150, 300) : $urandom_range(1, 40);
            repeat (run) begin
                if (left > 0) begin
                    tick_levels.push_back(($urandom_range(0, 99) < 4) ?
                                          3'($urandom_range(0, 7)) : 3'b111);
                    left--;
                end
            end
            mask = ($urandom_range(0, 99) < 75) ? 3'(1 << $urandom_range(0, 2)) :
                                                  3'($urandom_range(1, 7));
            hold = $urandom_range(1, 3);
            repeat (hold) begin
                if (left > 0) begin
                    tick_levels.push_back(~mask);
                    left--;
                end
            end
        end
    endtask

    initial begin
        logic [6:0] pct_list[7];
        pct_list = '{7'd0, 7'd127, 7'd1, 7'd100, 7'd50,
                     7'($urandom_range(2, 99)), 7'($urandom_range(101, 126))};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        tick_levels = '{3'd7, 3'd3, 3'd7, 3'd6, 3'd6, 3'd7, 3'd5, 3'd7, 3'd0, 3'd7,
                        3'd4, 3'd7, 3'd1, 3'd2, 3'd7, 3'd6, 3'd0, 3'd7, 3'd5, 3'd4};
        drain();
        foreach (pct_list[ph]) begin
            write_amp(pct_list[ph]);
            @(negedge i_clk);
            idle_on = (ph != 3);
            fill_random(PHASE_LEN);
            drain();
        end
        if (err_cnt == 0 && expected_points.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/gspg_pkg.sv
rtl/gspg_front.sv
rtl/gspg_queue.sv
rtl/gspg_back.sv
rtl/galvo_shape_point_generator.sv
dv/testbench.sv
